FILE: rtl/atcw_pkg.sv
`timescale 1ns / 1ps
// Package: widths, register indexes, tile codes and lane types of the texture address generator.
package atcw_pkg;

    localparam int COORD_BITS = 14;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = 32;
    localparam int CX_W       = COORD_BITS + 1;
    localparam int PROD_W     = COEF_W + CX_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int T_W        = ACC_W - FRAC_BITS - 1;
    localparam int PW         = COORD_BITS + 1;
    localparam int SIZE_W     = 2 * COORD_BITS;
    localparam int TDATA_W    = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int IDX_W      = 4;
    localparam int NDIV       = T_W;

    localparam logic [IDX_W-1:0] REG_COEF_A = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_COEF_B = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_COEF_C = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_COEF_D = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_COEF_E = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_COEF_F = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_TILE   = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_SIZE   = IDX_W'(7);

    localparam logic [1:0] TILE_CLAMP  = 2'd0;
    localparam logic [1:0] TILE_REPEAT = 2'd1;
    localparam logic [1:0] TILE_MIRROR = 2'd2;

    typedef struct packed {
        logic [T_W-1:0]        mag;
        logic                  neg;
        logic [PW-1:0]         rem;
        logic [COORD_BITS-1:0] clamp;
    } lane_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] tex_x;
        logic [COORD_BITS-1:0] tex_y;
        logic                  last;
    } res_t;

    // one restoring remainder step: bring in the top magnitude bit
    function automatic lane_t div_step(lane_t l, logic [PW-1:0] p);
        logic [PW:0] sh;
        lane_t       o;
        o  = l;
        sh = {l.rem, l.mag[T_W-1]};
        if (sh >= {1'b0, p})
            sh = sh - {1'b0, p};
        o.rem = sh[PW-1:0];
        o.mag = {l.mag[T_W-2:0], 1'b0};
        return o;
    endfunction

    function automatic logic [COORD_BITS-1:0] tile_fin(lane_t l, logic [PW-1:0] p,
                                                      logic [COORD_BITS-1:0] n,
                                                      logic [1:0] mode);
        logic [PW-1:0] r;
        r = l.rem;
        if (l.neg && r != '0)
            r = p - r;
        if (mode == TILE_MIRROR && r >= {1'b0, n})
            r = p - PW'(1) - r;
        case (mode)
            TILE_REPEAT, TILE_MIRROR: return r[COORD_BITS-1:0];
            default:                  return l.clamp;
        endcase
    endfunction

endpackage

FILE: rtl/affine_texture_coord_wrap_top.sv
`timescale 1ns / 1ps
// Top level: affine pixel-to-texel mapping with clamp, repeat and mirror tiling.
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | tdata pixel_x, pixel_y; tlast span_last
//  m_*     | out       | m_tvalid/m_tready  | tdata tex_x, tex_y; tlast span_end
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data register write
//
// One item per cycle while the output skid stage is empty. Items pass the input, product and
// sum registers, the bit-per-stage remainder pipeline that wraps the floored coordinate, and the output register.
// Reset clears all valid bits; the coefficient registers come up as identity.
// A full output skid stage holds the whole pipeline; s_tready is a register output.
module affine_texture_coord_wrap_top
    import atcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // pixel_x, pixel_y, zero pad
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // tex_x, tex_y, zero pad
    output logic               m_tlast,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [COEF_W-1:0]  cfg_data
);

    logic [COEF_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic [COEF_W-1:0] coef_d_reg, coef_e_reg, coef_f_reg;
    logic [1:0]        tile_reg;
    logic [SIZE_W-1:0] size_reg;

    logic [COORD_BITS-1:0] nx, ny;
    logic [PW-1:0]         px, py;

    logic en;

    logic                v1_reg, l1_reg;
    logic [CX_W-1:0]     cx_reg, cy_reg;
    logic                v2_reg, l2_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg, pd_reg, pe_reg;
    logic                v3_reg, l3_reg;
    logic signed [ACC_W-1:0] ax_reg, ay_reg;

    logic  dv_reg [0:NDIV];
    logic  dl_reg [0:NDIV];
    lane_t dx_reg [0:NDIV];
    lane_t dy_reg [0:NDIV];
    lane_t dx_next [0:NDIV];
    lane_t dy_next [0:NDIV];

    logic push;
    res_t res;
    logic m_v_reg, m_v_next, sk_v_reg, sk_v_next;
    res_t m_d_reg, m_d_next, sk_d_reg, sk_d_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= COEF_W'(65536);
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            coef_e_reg <= COEF_W'(65536);
            coef_f_reg <= '0;
            tile_reg   <= TILE_CLAMP;
            size_reg   <= SIZE_W'(16385);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_COEF_A: coef_a_reg <= cfg_data;
                REG_COEF_B: coef_b_reg <= cfg_data;
                REG_COEF_C: coef_c_reg <= cfg_data;
                REG_COEF_D: coef_d_reg <= cfg_data;
                REG_COEF_E: coef_e_reg <= cfg_data;
                REG_COEF_F: coef_f_reg <= cfg_data;
                REG_TILE:   tile_reg   <= cfg_data[1:0];
                REG_SIZE:   size_reg   <= cfg_data[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    // zero size acts as one; the user must keep config static while items are in flight (the block does not enforce it)
    always_comb
    begin
        nx = size_reg[COORD_BITS-1:0];
        ny = size_reg[SIZE_W-1:COORD_BITS];
        if (nx == '0)
            nx = COORD_BITS'(1);
        if (ny == '0)
            ny = COORD_BITS'(1);
        px = (tile_reg == TILE_MIRROR) ? {nx, 1'b0} : {1'b0, nx};
        py = (tile_reg == TILE_MIRROR) ? {ny, 1'b0} : {1'b0, ny};
    end

    assign en       = !sk_v_reg;
    assign s_tready = en;

    // entry of the remainder pipeline: floor, sign split and clamp value
    always_comb
    begin
        logic [T_W-1:0] tx, ty;
        tx = ax_reg[ACC_W-1:FRAC_BITS+1];
        ty = ay_reg[ACC_W-1:FRAC_BITS+1];
        dx_next[0].neg = tx[T_W-1];
        dx_next[0].mag = tx[T_W-1] ? (~tx + T_W'(1)) : tx;
        dx_next[0].rem = '0;
        if (tx[T_W-1])
            dx_next[0].clamp = '0;
        else if (tx > T_W'(nx - COORD_BITS'(1)))
            dx_next[0].clamp = nx - COORD_BITS'(1);
        else
            dx_next[0].clamp = tx[COORD_BITS-1:0];
        dy_next[0].neg = ty[T_W-1];
        dy_next[0].mag = ty[T_W-1] ? (~ty + T_W'(1)) : ty;
        dy_next[0].rem = '0;
        if (ty[T_W-1])
            dy_next[0].clamp = '0;
        else if (ty > T_W'(ny - COORD_BITS'(1)))
            dy_next[0].clamp = ny - COORD_BITS'(1);
        else
            dy_next[0].clamp = ty[COORD_BITS-1:0];
        for (int k = 0; k < NDIV; k++)
        begin
            dx_next[k+1] = div_step(dx_reg[k], px);
            dy_next[k+1] = div_step(dy_reg[k], py);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k <= NDIV; k++)
                dv_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            dv_reg[0] <= v3_reg;
            for (int k = 0; k < NDIV; k++)
                dv_reg[k+1] <= dv_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= {s_tdata[COORD_BITS-1:0], 1'b1};
            cy_reg <= {s_tdata[2*COORD_BITS-1:COORD_BITS], 1'b1};
            l1_reg <= s_tlast;
            pa_reg <= $signed(coef_a_reg) * $signed({1'b0, cx_reg});
            pb_reg <= $signed(coef_b_reg) * $signed({1'b0, cy_reg});
            pd_reg <= $signed(coef_d_reg) * $signed({1'b0, cx_reg});
            pe_reg <= $signed(coef_e_reg) * $signed({1'b0, cy_reg});
            l2_reg <= l1_reg;
            ax_reg <= ACC_W'(pa_reg) + ACC_W'(pb_reg)
                    + $signed({{(ACC_W-COEF_W-1){coef_c_reg[COEF_W-1]}}, coef_c_reg, 1'b0});
            ay_reg <= ACC_W'(pd_reg) + ACC_W'(pe_reg)
                    + $signed({{(ACC_W-COEF_W-1){coef_f_reg[COEF_W-1]}}, coef_f_reg, 1'b0});
            l3_reg <= l2_reg;
            dl_reg[0] <= l3_reg;
            for (int k = 0; k <= NDIV; k++)
            begin
                dx_reg[k] <= dx_next[k];
                dy_reg[k] <= dy_next[k];
            end
            for (int k = 0; k < NDIV; k++)
                dl_reg[k+1] <= dl_reg[k];
        end
    end

    assign push      = en && dv_reg[NDIV];
    assign res.tex_x = tile_fin(dx_reg[NDIV], px, nx, tile_reg);
    assign res.tex_y = tile_fin(dy_reg[NDIV], py, ny, tile_reg);
    assign res.last  = dl_reg[NDIV];

    always_comb
    begin
        m_v_next  = m_v_reg;
        m_d_next  = m_d_reg;
        sk_v_next = sk_v_reg;
        sk_d_next = sk_d_reg;
        if (m_tready || !m_v_reg)
        begin
            if (sk_v_reg)
            begin
                m_v_next  = 1'b1;
                m_d_next  = sk_d_reg;
                sk_v_next = 1'b0;
            end
            else
            begin
                m_v_next = push;
                m_d_next = res;
            end
        end
        else if (push)
        begin
            sk_v_next = 1'b1;
            sk_d_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg  <= 1'b0;
            sk_v_reg <= 1'b0;
        end
        else
        begin
            m_v_reg  <= m_v_next;
            sk_v_reg <= sk_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_d_reg  <= m_d_next;
        sk_d_reg <= sk_d_next;
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = TDATA_W'({m_d_reg.tex_y, m_d_reg.tex_x});
    assign m_tlast  = m_d_reg.last;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_v_reg |-> m_v_reg)
        else $error("skid holds an item while output is empty");
    a_tex_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_v_reg |-> (m_d_reg.tex_x < nx))
        else $error("tex_x not below width");
    a_tex_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_v_reg |-> (m_d_reg.tex_y < ny))
        else $error("tex_y not below height");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench: texture address generator, self-checked against an inline texel predictor.
module tb_top;
    import atcw_pkg::*;

    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(15);
    localparam int LATENCY_WAIT = NDIV + 20;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // pixel_x, pixel_y, zero pad
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // tex_x, tex_y, zero pad
    logic               m_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [COEF_W-1:0]  cfg_data;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  span;
    } pixel_t;

    pixel_t pixel_q[$];
    res_t   texel_q[$];

    // predictor copy of the register file
    logic signed [31:0]   w_a, w_b, w_c, w_d, w_e, w_f;
    logic [1:0]           w_tile;
    logic [SIZE_W-1:0]    w_size;

    int  mismatches;
    bit  calm;        // no idling on either side
    bit  hold_req;
    bit  hold_done;
    int  hold_cnt;

    affine_texture_coord_wrap_top i_dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [COORD_BITS-1:0] wrap_axis(longint t, longint n);
        longint r;
        if (n == 0)
            n = 1;
        if (w_tile == TILE_REPEAT)
        begin
            r = t % n;
            if (r < 0)
                r += n;
        end
        else if (w_tile == TILE_MIRROR)
        begin
            r = t % (2 * n);
            if (r < 0)
                r += 2 * n;
            if (r >= n)
                r = 2 * n - 1 - r;
        end
        else
        begin
            r = (t < 0) ? 0 : t;
            if (r > n - 1)
                r = n - 1;
        end
        return r[COORD_BITS-1:0];
    endfunction

    function automatic res_t texel_of(pixel_t p);
        longint cx, cy, u, v;
        res_t   r;
        cx = 2 * longint'(p.px) + 1;
        cy = 2 * longint'(p.py) + 1;
        u  = (longint'(w_a) * cx + longint'(w_b) * cy + 2 * longint'(w_c)) >>> (FRAC_BITS + 1);
        v  = (longint'(w_d) * cx + longint'(w_e) * cy + 2 * longint'(w_f)) >>> (FRAC_BITS + 1);
        r.tex_x = wrap_axis(u, longint'(w_size[COORD_BITS-1:0]));
        r.tex_y = wrap_axis(v, longint'(w_size[SIZE_W-1:COORD_BITS]));
        r.last  = p.span;
        return r;
    endfunction

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pixel_q.size() > 0 && (calm || $urandom_range(99) >= 17))
            begin
                pixel_t p;
                p = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= TDATA_W'({p.py, p.px});
                s_tlast  <= p.span;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // texel receiver, with one long hold-off to back the pipe up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cnt  <= 300;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || $urandom_range(99) >= 17;
    end

    // monitor: predict on pixel accept, check on texel accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                texel_q.push_back(texel_of(pixel_t'({s_tdata[COORD_BITS-1:0],
                                      s_tdata[SIZE_W-1:COORD_BITS], s_tlast})));
            if (m_tvalid && m_tready)
            begin
                res_t want, got;
                got = res_t'({m_tdata[COORD_BITS-1:0], m_tdata[SIZE_W-1:COORD_BITS], m_tlast});
                if (texel_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected texel x=%0d y=%0d last=%0d",
                                 got.tex_x, got.tex_y, got.last);
                end
                else
                begin
                    want = texel_q.pop_front();
                    if (got != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"texel mismatch: want x=%0d y=%0d last=%0d, ",
                                      "got x=%0d y=%0d last=%0d"},
                                     want.tex_x, want.tex_y, want.last,
                                     got.tex_x, got.tex_y, got.last);
                    end
                end
            end
        end
    end

    task automatic reg_write(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_COEF_A: w_a = data;
            REG_COEF_B: w_b = data;
            REG_COEF_C: w_c = data;
            REG_COEF_D: w_d = data;
            REG_COEF_E: w_e = data;
            REG_COEF_F: w_f = data;
            REG_TILE:   w_tile = data[1:0];
            REG_SIZE:   w_size = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic add_pixel(int x, int y, bit span);
        pixel_t p;
        p.px   = COORD_BITS'(x);
        p.py   = COORD_BITS'(y);
        p.span = span;
        pixel_q.push_back(p);
    endtask

    // sample between edges so the driver's pop and s_tvalid agree
    task automatic drain();
        @(negedge clk);
        while (pixel_q.size() > 0 || s_tvalid || texel_q.size() > 0)
            @(negedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        return COEF_W'($signed($urandom) >>> $urandom_range(24, 8));
    endfunction

    function automatic logic [COEF_W-1:0] rand_size();
        logic [COORD_BITS-1:0] w, h;
        w = ($urandom_range(9) == 0) ? COORD_BITS'($urandom) : COORD_BITS'($urandom_range(40));
        h = ($urandom_range(9) == 0) ? COORD_BITS'($urandom) : COORD_BITS'($urandom_range(40));
        return {4'($urandom), h, w};
    endfunction

    initial
    begin
        int ph;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        mismatches = 0;
        w_a = 32'sd65536; w_b = 0; w_c = 0; w_d = 0; w_e = 32'sd65536; w_f = 0;
        w_tile = TILE_CLAMP;
        w_size = SIZE_W'(16385);
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset identity mapping onto a 1x1 bitmap
        add_pixel(0, 0, 1'b0);
        add_pixel(16383, 16383, 1'b1);
        drain();

        // extremes of every coefficient, full-size bitmap, each tile mode
        reg_write(REG_COEF_A, 32'h7fffffff);
        reg_write(REG_COEF_B, 32'h80000000);
        reg_write(REG_COEF_C, 32'h7fffffff);
        reg_write(REG_COEF_D, 32'h80000000);
        reg_write(REG_COEF_E, 32'h80000000);
        reg_write(REG_COEF_F, 32'h80000000);
        reg_write(REG_SIZE, {4'hf, 14'h3fff, 14'h3fff});
        for (int m = 0; m < 4; m++)
        begin
            reg_write(REG_TILE, COEF_W'(m));
            add_pixel(0, 0, 1'b0);
            add_pixel(16383, 0, 1'b1);
            add_pixel(0, 16383, 1'b0);
            add_pixel(16383, 16383, 1'b1);
            add_pixel(8191, 8192, 1'b0);
            drain();
        end

        // zero width and height behave as one; unused index is ignored
        reg_write(REG_SIZE, '0);
        reg_write(REG_UNUSED, 32'hdeadbeef);
        add_pixel(100, 200, 1'b1);
        add_pixel(16383, 1, 1'b0);
        drain();

        for (ph = 0; ph < 9; ph++)
        begin
            reg_write(REG_COEF_A, rand_coef());
            reg_write(REG_COEF_B, rand_coef());
            reg_write(REG_COEF_C, $urandom);
            reg_write(REG_COEF_D, rand_coef());
            reg_write(REG_COEF_E, rand_coef());
            reg_write(REG_COEF_F, $urandom);
            reg_write(REG_TILE, COEF_W'(ph % 4));
            reg_write(REG_SIZE, rand_size());
            calm     = (ph == 3);
            hold_req = (ph == 5);
            for (int i = 0; i < 70; i++)
                add_pixel($urandom_range(16383), $urandom_range(16383),
                          1'($urandom_range(1)));
            drain();
        end

        if (mismatches == 0 && texel_q.size() == 0 && pixel_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
